FILE: src/double_ended_list_store_top_assert.svh
// Assertion macros for the list store sequencer.
// The enclosing module must provide clk_i and rst_ni.
`ifndef DOUBLE_ENDED_LIST_STORE_TOP_ASSERT_SVH
`define DOUBLE_ENDED_LIST_STORE_TOP_ASSERT_SVH

// The property must hold at every clock edge outside reset.
`define DELS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DELS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/dels_pkg.sv
package dels_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned DW    = 32;
  localparam int unsigned OPW   = 3;
  localparam int unsigned STW   = 2;
  localparam int unsigned CNTW  = 5;

  typedef logic [AW-1:0]        addr_t;
  typedef logic [CW-1:0]        cnt_t;
  typedef logic signed [DW-1:0] data_t;

  typedef enum logic [OPW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REMOVE     = 3'd4,
    OP_CLEAR      = 3'd5,
    OP_LIST       = 3'd6
  } op_e;

  typedef enum logic [STW-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_ABSENT = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP_WAIT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_LIST_RD,
    S_LIST_WAIT,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    data_t wdata;
    logic  re;
    addr_t raddr;
  } ram_req_t;

  typedef struct packed {
    status_e status;
    data_t   value;
    cnt_t    count;
    logic    last;
  } res_t;

  // Position in the ring that lies offset places behind base.
  function automatic addr_t ring_add(addr_t base, cnt_t offset);
    logic [AW:0] sum;
    sum = {1'b0, base} + (AW+1)'(offset);
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

endpackage

FILE: src/dels_if.sv
interface dels_in_if;
  import dels_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OPW-1:0]       opcode;
  logic signed [DW-1:0] item_value;

  modport source (output valid, output opcode, output item_value, input ready);
  modport sink (input valid, input opcode, input item_value, output ready);
endinterface

interface dels_out_if;
  import dels_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STW-1:0]       status;
  logic signed [DW-1:0] read_value;
  logic [CNTW-1:0]      entry_count;
  logic                 last_of_run;

  modport source (
    output valid, output status, output read_value, output entry_count,
    output last_of_run, input ready
  );
  modport sink (
    input valid, input status, input read_value, input entry_count,
    input last_of_run, output ready
  );
endinterface

FILE: src/dels_ram.sv
module dels_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/dels_seq.sv
module dels_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  dels_in_if.sink            in_i,
  output dels_pkg::ram_req_t ram_o,
  input  dels_pkg::data_t    rdata_i,
  output logic               res_valid_o,
  output dels_pkg::res_t     res_o,
  input  logic               res_ready_i
);
  import dels_pkg::*;

  `include "double_ended_list_store_top_assert.svh"

  localparam cnt_t ONE = cnt_t'(1);

  state_e  state_q, state_d;
  addr_t   front_q, front_d;
  cnt_t    count_q, count_d;
  cnt_t    idx_q, idx_d;
  data_t   key_q, key_d;
  status_e st_q, st_d;
  data_t   val_q, val_d;
  logic    last_q, last_d;
  logic    accept;
  logic    full;
  logic    empty;
  cnt_t    idx_next;

  assign in_i.ready  = (state_q == S_IDLE);
  assign accept      = in_i.valid && in_i.ready;
  assign full        = (count_q == cnt_t'(DEPTH));
  assign empty       = (count_q == '0);
  assign idx_next    = idx_q + ONE;
  assign res_valid_o = (state_q == S_EMIT);
  assign res_o       = '{status: st_q, value: val_q, count: count_q, last: last_q};

  always_comb begin
    state_d = state_q;
    front_d = front_q;
    count_d = count_q;
    idx_d   = idx_q;
    key_d   = key_q;
    st_d    = st_q;
    val_d   = val_q;
    last_d  = last_q;
    ram_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          st_d    = ST_OK;
          val_d   = '0;
          last_d  = 1'b1;
          key_d   = in_i.item_value;
          idx_d   = '0;
          state_d = S_EMIT;
          case (in_i.opcode)
            OP_PUSH_FRONT: begin
              if (full) begin
                st_d = ST_FULL;
              end else begin
                front_d     = ring_add(front_q, cnt_t'(DEPTH - 1));
                ram_o.we    = 1'b1;
                ram_o.waddr = front_d;
                ram_o.wdata = in_i.item_value;
                count_d     = count_q + ONE;
              end
            end
            OP_PUSH_BACK: begin
              if (full) begin
                st_d = ST_FULL;
              end else begin
                ram_o.we    = 1'b1;
                ram_o.waddr = ring_add(front_q, count_q);
                ram_o.wdata = in_i.item_value;
                count_d     = count_q + ONE;
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                st_d = ST_EMPTY;
              end else begin
                ram_o.re    = 1'b1;
                ram_o.raddr = front_q;
                front_d     = ring_add(front_q, ONE);
                count_d     = count_q - ONE;
                state_d     = S_POP_WAIT;
              end
            end
            OP_POP_BACK: begin
              if (empty) begin
                st_d = ST_EMPTY;
              end else begin
                ram_o.re    = 1'b1;
                ram_o.raddr = ring_add(front_q, count_q - ONE);
                count_d     = count_q - ONE;
                state_d     = S_POP_WAIT;
              end
            end
            OP_REMOVE: begin
              if (empty) begin
                st_d = ST_EMPTY;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
            OP_CLEAR: begin
              count_d = '0;
              front_d = '0;
            end
            OP_LIST: begin
              if (empty) begin
                st_d = ST_EMPTY;
              end else begin
                state_d = S_LIST_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP_WAIT: begin
        val_d   = rdata_i;
        state_d = S_EMIT;
      end
      S_SCAN_RD: begin
        ram_o.re    = 1'b1;
        ram_o.raddr = ring_add(front_q, idx_q);
        state_d     = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (rdata_i == key_q) begin
          state_d = S_SHIFT_RD;
        end else if (idx_next == count_q) begin
          st_d    = ST_ABSENT;
          state_d = S_EMIT;
        end else begin
          idx_d   = idx_next;
          state_d = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        if (idx_next < count_q) begin
          ram_o.re    = 1'b1;
          ram_o.raddr = ring_add(front_q, idx_next);
          state_d     = S_SHIFT_WR;
        end else begin
          count_d = count_q - ONE;
          val_d   = key_q;
          state_d = S_EMIT;
        end
      end
      S_SHIFT_WR: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = ring_add(front_q, idx_q);
        ram_o.wdata = rdata_i;
        idx_d       = idx_next;
        state_d     = S_SHIFT_RD;
      end
      S_LIST_RD: begin
        ram_o.re    = 1'b1;
        ram_o.raddr = ring_add(front_q, idx_q);
        state_d     = S_LIST_WAIT;
      end
      S_LIST_WAIT: begin
        val_d   = rdata_i;
        last_d  = (idx_next == count_q);
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (res_ready_i) begin
          if (last_q) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_next;
            state_d = S_LIST_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      front_q <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    key_q  <= key_d;
    st_q   <= st_d;
    val_q  <= val_d;
    last_q <= last_d;
  end

  `DELS_ASSERT(a_count_range, count_q <= cnt_t'(DEPTH), "Entry count exceeds the depth.")
  `DELS_ASSERT(a_front_range, {1'b0, front_q} < (AW+1)'(DEPTH), "Front position is off the ring.")
  `DELS_ASSERT_NEXT(a_push_grows, accept && !full && (in_i.opcode == OP_PUSH_FRONT || in_i.opcode == OP_PUSH_BACK), count_q == $past(count_q) + ONE, "A push did not add one entry.")
  `DELS_ASSERT_NEXT(a_clear_resets, accept && in_i.opcode == OP_CLEAR, count_q == '0 && front_q == '0, "Clear left entries behind.")
  `DELS_ASSERT_NEXT(a_result_holds, res_valid_o && !res_ready_i, res_valid_o && $stable(val_q) && $stable(st_q) && $stable(last_q), "A stalled result changed.")

endmodule

FILE: src/double_ended_list_store_top.sv
// Bounded double-ended list of signed 32-bit values with removal by value.
// The in_i channel takes one item per operation: an opcode and a value. The
// out_o channel returns results, each with a status, a value, the entry count
// after the operation, and a last flag that marks the final result of an item.
// Every operation gives one result, except list all on a non-empty list, which
// gives one result per held entry from front to back.
// Items are handled one at a time by a small sequencer around a dual-port entry
// memory with registered read, so in_i is ready only while it is idle.
// From acceptance to the first result on out_o: push, clear, unknown codes and
// every error on an empty or full list pass through the result state and then
// the output register; pops that return a value first wait for the memory read.
// Remove reads and compares entries from the front until it finds the value or
// has compared them all, then moves each later entry one place toward the front
// to close the gap. List all reads, waits for and emits each entry in turn. The
// next item is taken in the cycle after the last result enters the output register.
// A result waits in the output register while out_o is stalled, and the
// sequencer holds the following result until that register frees up.
// Reset empties the list at once; no clearing pass is needed.
module double_ended_list_store_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  dels_in_if.sink    in_i,
  dels_out_if.source out_o
);
  import dels_pkg::*;

  ram_req_t ram_req;
  data_t    rdata;
  logic     res_valid;
  logic     res_ready;
  res_t     res;
  logic     out_valid_q;
  res_t     out_q;

  dels_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .ram_o       (ram_req),
    .rdata_i     (rdata),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  dels_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (rdata)
  );

  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_q.status;
  assign out_o.read_value  = out_q.value;
  assign out_o.entry_count = CNTW'(out_q.count);
  assign out_o.last_of_run = out_q.last;

endmodule
